### rtl/rbd_pkg.sv
// ============================================================================
// rbd_pkg
// Shared types and constants for the ring buffer deque.
// ============================================================================
package rbd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_POP_FRONT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_BACK,
    OP_SHIFT_BACK,
    OP_SHIFT_FRONT,
    OP_DROP_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

### rtl/rbd_if.sv
// ============================================================================
// rbd_if
// Valid/ready channels for deque commands and results.
// ============================================================================
interface rbd_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic signed [rbd_pkg::DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface rbd_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [rbd_pkg::CNT_W-1:0]         count;
  logic signed [rbd_pkg::DATA_W-1:0] front_value;
  logic signed [rbd_pkg::DATA_W-1:0] back_value;

  modport source (output valid, status, count, front_value, back_value, input ready);
  modport sink   (input valid, status, count, front_value, back_value, output ready);
endinterface

### rtl/rbd_cell.sv
// ============================================================================
// rbd_cell
// One deque slot: a valid flag and a word, shifting with its neighbors.
// ============================================================================
module rbd_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  rbd_pkg::cell_ctl_t                ctl,
  input  logic                              prev_valid,
  input  logic signed [rbd_pkg::DATA_W-1:0] prev_data,
  input  logic                              next_valid,
  input  logic signed [rbd_pkg::DATA_W-1:0] next_data,
  output logic                              valid,
  output logic signed [rbd_pkg::DATA_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        rbd_pkg::OP_LOAD_BACK:   if (!valid && prev_valid) valid <= 1'b1;
        rbd_pkg::OP_SHIFT_BACK:  valid <= prev_valid;
        rbd_pkg::OP_SHIFT_FRONT: valid <= next_valid;
        rbd_pkg::OP_DROP_BACK:   valid <= valid && next_valid;
        default:                 valid <= valid;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    case (ctl.op)
      rbd_pkg::OP_LOAD_BACK:   if (!valid && prev_valid) data <= ctl.value;
      rbd_pkg::OP_SHIFT_BACK:  data <= prev_data;
      rbd_pkg::OP_SHIFT_FRONT: data <= next_data;
      default:                 data <= data;
    endcase
  end

endmodule

### rtl/ring_buffer_deque_top.sv
// ============================================================================
// ring_buffer_deque_top
// Double-ended queue of signed words held in a row of shifting cells.
// ============================================================================
// Usage:
//   cmd  (sink)  : one word per operation - kind (push back, push front,
//                  pop back, pop front) and value (used by pushes only).
//   res  (source): one word per command - status, count after the command,
//                  front and back values (both 0 when empty).
// Structure: a row of DEPTH cells, cell 0 being the front. Push front and
//   pop front shift the whole row one step; push back loads the first free
//   cell; pop back clears the last occupied cell. The back value is picked
//   from the cell whose right neighbor is empty.
// Latency: a result appears the cycle after its command is taken.
// Throughput: one command per cycle while res is not held off, set by the
//   single update of the cell row per command; the result register takes a
//   new word whenever it is empty or being read in the same cycle.
// Stall: while res is held off, cmd.ready stays low and the cells hold.
// Reset: all cells empty, count zero, no result pending. Cell data is not
//   reset; only occupied cells are ever shown.
// Full pushes report status 1 and change nothing; pops on an empty deque
//   report status 2 and change nothing.
// ============================================================================
module ring_buffer_deque_top (
  input  logic      clk,
  input  logic      rst,
  rbd_cmd_if.sink   cmd,
  rbd_res_if.source res
);

  localparam int D = rbd_pkg::DEPTH;
  localparam int W = rbd_pkg::DATA_W;
  localparam int C = rbd_pkg::CNT_W;

  logic [D-1:0]          vld;
  logic signed [W-1:0]   data [D];
  logic [D-1:0]          last;

  rbd_pkg::cell_ctl_t    ctl;
  rbd_pkg::status_t      st_next;
  rbd_pkg::status_t      status;
  logic [C-1:0]          count;
  logic [C-1:0]          count_next;
  logic                  out_valid;
  logic                  take;
  logic                  full;
  logic                  empty;
  logic signed [W-1:0]   back_sel;

  assign full  = vld[D-1];
  assign empty = !vld[0];

  assign cmd.ready = !out_valid || res.ready;
  assign take      = cmd.valid && cmd.ready;

  // command decode into a cell-row operation
  always_comb begin
    ctl.value  = cmd.value;
    ctl.op     = rbd_pkg::OP_HOLD;
    st_next    = rbd_pkg::ST_DONE;
    count_next = count;
    case (rbd_pkg::kind_t'(cmd.kind))
      rbd_pkg::KIND_PUSH_BACK: begin
        if (full) st_next = rbd_pkg::ST_FULL;
        else begin
          ctl.op     = rbd_pkg::OP_LOAD_BACK;
          count_next = count + C'(1);
        end
      end
      rbd_pkg::KIND_PUSH_FRONT: begin
        if (full) st_next = rbd_pkg::ST_FULL;
        else begin
          ctl.op     = rbd_pkg::OP_SHIFT_BACK;
          count_next = count + C'(1);
        end
      end
      rbd_pkg::KIND_POP_BACK: begin
        if (empty) st_next = rbd_pkg::ST_EMPTY;
        else begin
          ctl.op     = rbd_pkg::OP_DROP_BACK;
          count_next = count - C'(1);
        end
      end
      rbd_pkg::KIND_POP_FRONT: begin
        if (empty) st_next = rbd_pkg::ST_EMPTY;
        else begin
          ctl.op     = rbd_pkg::OP_SHIFT_FRONT;
          count_next = count - C'(1);
        end
      end
      default: ctl.op = rbd_pkg::OP_HOLD;
    endcase
    if (!take) begin
      ctl.op     = rbd_pkg::OP_HOLD;
      count_next = count;
    end
  end

  // cell row: the head sees a valid neighbor carrying cmd.value; the tail sees an empty one
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                pv;
    logic signed [W-1:0] pd;
    logic                nv;
    logic signed [W-1:0] nd;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pd = cmd.value;
    end else begin : g_mid
      assign pv = vld[i-1];
      assign pd = data[i-1];
    end
    if (i == D-1) begin : g_tail
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_rest
      assign nv = vld[i+1];
      assign nd = data[i+1];
    end

    rbd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (pv),
      .prev_data  (pd),
      .next_valid (nv),
      .next_data  (nd),
      .valid      (vld[i]),
      .data       (data[i])
    );
  end

  // last occupied cell marks the back
  assign last = vld & ~(vld >> 1);

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < D; i++) begin
      back_sel = back_sel | (data[i] & {W{last[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      count <= count_next;
      if (take) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) status <= st_next;
  end

  assign res.valid       = out_valid;
  assign res.status      = status;
  assign res.count       = count;
  assign res.front_value = vld[0] ? data[0] : '0;
  assign res.back_value  = back_sel;

  // occupied cells always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld >> 1) & ~vld) == '0)
    else $error("deque cells not contiguous");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(count))
    else $error("count does not match occupied cells");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rbd_pkg::ST_FULL |-> count == C'(D))
    else $error("full status with free cells");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rbd_pkg::ST_EMPTY |-> count == '0 && !vld[0])
    else $error("empty status with occupied cells");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |=> $stable(vld) && $stable(count))
    else $error("cells changed under a stalled result");

endmodule
